[rtl/core/cpf_pkg.sv]
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and fixed-point helpers of the camera projection
// and frustum unit.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int ACC_W     = 52;
  localparam int DIV_STEPS = WORD_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int SQ_STEPS  = WORD_W;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS + 1);
  localparam int SUMSQ_W   = PROD_W - FRAC_BITS;

  localparam int VP_MACS    = 64;
  localparam int CLIP_MACS  = 16;
  localparam int SCR_OPS    = 5;
  localparam int SSQ_OPS    = 3;
  localparam int PLB_STEPS  = 8;

  typedef logic signed [WORD_W-1:0] q_t;

  localparam q_t ONE   = q_t'(1) <<< FRAC_BITS;
  localparam q_t HALF  = q_t'(1) <<< (FRAC_BITS - 1);
  localparam q_t Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] ACC_HI =
    {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = ~ACC_HI;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_PROJECT = 2'd1,
    OP_FRUSTUM = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_W_ZERO   = 2'd1;
  localparam logic [1:0] ST_LEN_ZERO = 2'd2;

  localparam logic [2:0] PLANE_FAR = 3'd5;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef enum logic [1:0] {
    MM_VP   = 2'd0,
    MM_CLIP = 2'd1,
    MM_SCR  = 2'd2,
    MM_SSQ  = 2'd3
  } mac_mode_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        matrix_select;
    logic [3:0]  element_index;
    q_t          element_value;
    q_t          world_x;
    q_t          world_y;
    q_t          world_z;
  } in_word_t;

  typedef struct packed {
    q_t          screen_x;
    q_t          screen_y;
    q_t          screen_depth;
    q_t          plane_a;
    q_t          plane_b;
    q_t          plane_c;
    q_t          plane_d;
    logic [2:0]  plane_index;
    logic        last_of_run;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic       mac_go;
    mac_mode_t  mac_mode;
    logic [5:0] step;
    logic       pl_go;
    logic [2:0] pl_step;
    logic [2:0] plane_k;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_plane;
    logic       sq_start;
    logic       emit;
    logic       emit_plane;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic sq_done;
    logic sq_busy;
    logic w_zero;
    logic len_zero;
    logic out_free;
  } sts_t;

  function automatic logic signed [ACC_W-1:0] ext_q(input q_t v);
    ext_q = {{(ACC_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

  function automatic q_t sat_q(input logic signed [ACC_W-1:0] v);
    q_t r;
    if (v > ACC_HI) r = Q_MAX;
    else if (v < ACC_LO) r = Q_MIN;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

endpackage

[rtl/core/cpf_div.sv]
// ----------------------------------------------------------------------------
// cpf_div
// Restoring divider, one quotient bit per cycle; fixed-point quotient
// rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module cpf_div
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  q_t                num,
  input  logic [WORD_W-1:0] den_mag,
  input  logic              den_neg,
  output logic              busy,
  output logic              done,
  output q_t                quo
);

  logic                 busy_r, fin_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_STEPS-1:0] n_r, q_r;
  logic [WORD_W:0]      rem_r;
  logic [WORD_W-1:0]    den_r;
  logic                 neg_r;
  q_t                   quo_r;

  logic [WORD_W-1:0]    num_mag;
  logic [WORD_W+1:0]    rem_sh, rem_sub;
  logic                 take;
  logic [DIV_STEPS:0]   q_inc;
  logic [DIV_STEPS-1:0] q_rnd;
  q_t                   quo_nxt;

  assign num_mag = num[WORD_W-1] ? WORD_W'(-num) : num;
  assign rem_sh  = {rem_r, n_r[DIV_STEPS-1]};
  assign rem_sub = rem_sh - {2'b00, den_r};
  assign take    = rem_sh >= {2'b00, den_r};
  assign q_inc   = {1'b0, q_r} + (DIV_STEPS+1)'(1);
  assign q_rnd   = q_inc[DIV_STEPS:1];

  always_comb begin
    if (neg_r) begin
      if (q_rnd > DIV_STEPS'({1'b1, {(WORD_W-1){1'b0}}})) quo_nxt = Q_MIN;
      else quo_nxt = q_t'(-q_rnd[WORD_W-1:0]);
    end else begin
      if (q_rnd > DIV_STEPS'(Q_MAX)) quo_nxt = Q_MAX;
      else quo_nxt = q_rnd[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {num_mag, {(FRAC_BITS+1){1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
      den_r <= den_mag;
      neg_r <= num[WORD_W-1] ^ den_neg;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_STEPS-2:0], 1'b0};
      q_r   <= {q_r[DIV_STEPS-2:0], take};
      rem_r <= take ? rem_sub[WORD_W:0] : rem_sh[WORD_W:0];
    end
    if (fin_r) quo_r <= quo_nxt;
  end

  assign busy = busy_r | fin_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/core/cpf_sqrt.sv]
// ----------------------------------------------------------------------------
// cpf_sqrt
// Integer square root, one root bit per cycle (digit-by-digit).
// ----------------------------------------------------------------------------
module cpf_sqrt
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] rad,
  output logic              busy,
  output logic              done,
  output logic [WORD_W-1:0] root
);

  logic                busy_r, done_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]   rad_r;
  logic [WORD_W+1:0]   rem_r;
  logic [WORD_W-1:0]   root_r;

  logic [WORD_W+3:0]   rem_sh, trial;
  logic                take;

  assign rem_sh = {rem_r, rad_r[PROD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CNT_W'(SQ_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SQ_CNT_W'(1);
        if (cnt_r == SQ_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[PROD_W-3:0], 2'b00};
      rem_r  <= take ? (WORD_W+2)'(rem_sh - trial) : rem_sh[WORD_W+1:0];
      root_r <= {root_r[WORD_W-2:0], take};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/core/cpf_ctrl.sv]
// ----------------------------------------------------------------------------
// cpf_ctrl
// Sequencer: steps the shared datapath through matrix product, clip transform
// or plane build, divides, square root, screen mapping and result output.
// ----------------------------------------------------------------------------
module cpf_ctrl
  import cpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_op,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_VP     = 13'h0002,
    S_CLIP   = 13'h0004,
    S_PCHK   = 13'h0008,
    S_DIV_GO = 13'h0010,
    S_DIV_WT = 13'h0020,
    S_SCR    = 13'h0040,
    S_EMIT   = 13'h0080,
    S_PLB    = 13'h0100,
    S_SSQ    = 13'h0200,
    S_SQ_GO  = 13'h0400,
    S_SQ_WT  = 13'h0800,
    S_LCHK   = 13'h1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [2:0] k_r, k_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       plane_r, plane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      sel_r   <= '0;
      plane_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      sel_r   <= sel_nxt;
      plane_r <= plane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    plane_nxt = plane_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_op == OP_PROJECT || in_op == OP_FRUSTUM)) begin
          state_nxt = S_VP;
          cnt_nxt   = '0;
          plane_nxt = (in_op == OP_FRUSTUM);
        end
      end
      S_VP: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(VP_MACS)) begin
          cnt_nxt   = '0;
          k_nxt     = '0;
          state_nxt = plane_r ? S_PLB : S_CLIP;
        end
      end
      S_CLIP: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(CLIP_MACS)) begin
          cnt_nxt   = '0;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        sel_nxt   = '0;
        state_nxt = sts.w_zero ? S_EMIT : S_DIV_GO;
      end
      S_DIV_GO: state_nxt = S_DIV_WT;
      S_DIV_WT: begin
        if (sts.div_done) begin
          if (sel_r == (plane_r ? 2'd3 : 2'd2)) begin
            cnt_nxt   = '0;
            state_nxt = plane_r ? S_EMIT : S_SCR;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_SCR: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(SCR_OPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          if (!plane_r || k_r == PLANE_FAR) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 3'd1;
            cnt_nxt   = '0;
            state_nxt = S_PLB;
          end
        end
      end
      S_PLB: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(PLB_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SSQ;
        end
      end
      S_SSQ: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(SSQ_OPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ_GO;
        end
      end
      S_SQ_GO: state_nxt = S_SQ_WT;
      S_SQ_WT: if (sts.sq_done) state_nxt = S_LCHK;
      S_LCHK: begin
        sel_nxt   = '0;
        state_nxt = sts.len_zero ? S_EMIT : S_DIV_GO;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.step       = cnt_r[5:0];
    cmd.pl_step    = cnt_r[2:0];
    cmd.plane_k    = k_r;
    cmd.div_sel    = sel_r;
    cmd.div_plane  = plane_r;
    cmd.emit_plane = plane_r;
    cmd.mac_mode   = MM_VP;
    unique case (state_r)
      S_VP: cmd.mac_go = (cnt_r < 7'(VP_MACS));
      S_CLIP: begin
        cmd.mac_mode = MM_CLIP;
        cmd.mac_go   = (cnt_r < 7'(CLIP_MACS));
      end
      S_SCR: begin
        cmd.mac_mode = MM_SCR;
        cmd.mac_go   = (cnt_r < 7'(SCR_OPS));
      end
      S_SSQ: begin
        cmd.mac_mode = MM_SSQ;
        cmd.mac_go   = (cnt_r < 7'(SSQ_OPS));
      end
      S_PLB:    cmd.pl_go     = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_SQ_GO:  cmd.sq_start  = 1'b1;
      S_EMIT:   cmd.emit      = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/cpf_dp.sv]
// ----------------------------------------------------------------------------
// cpf_dp
// Datapath: matrix storage, shared multiply-accumulate, plane builder,
// divider, square root and output word register.
// ----------------------------------------------------------------------------
module cpf_dp
  import cpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  in_word_t      in_word,
  input  logic [13:0]   org_x,
  input  logic [13:0]   org_y,
  input  logic [14:0]   vp_w,
  input  logic [14:0]   vp_h,
  input  cmd_t          cmd,
  input  logic          out_stall,
  output sts_t          sts,
  output logic          out_valid,
  output out_word_t     out_word
);

  q_t pm_r [16];
  q_t vm_r [16];
  q_t vp_r [16];
  q_t pt_r [3];
  q_t clip_r [4];
  q_t nd_r [3];
  q_t u_r [2];
  q_t scr_r [3];
  q_t pv_r [4];
  q_t pa_r [4];
  q_t tmp_r;
  logic [SUMSQ_W-1:0] s_r;

  logic [PROD_W-1:0]        prod_mag_r;
  logic                     prod_neg_r;
  logic                     d_valid_r, d_first_r, d_last_r;
  mac_mode_t                d_mode_r;
  logic [5:0]               d_step_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic      out_valid_r;
  out_word_t out_r, out_nxt;

  // multiplier operands
  q_t                       mul_a, mul_b, wp;
  logic [WORD_W-1:0]        mag_a, mag_b;
  logic                     first, last;

  always_comb begin
    unique case (cmd.step[1:0])
      2'd0: wp = pt_r[0];
      2'd1: wp = pt_r[1];
      2'd2: wp = pt_r[2];
      default: wp = ONE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    first = 1'b1;
    last  = 1'b1;
    unique case (cmd.mac_mode)
      MM_VP: begin
        mul_a = pm_r[{cmd.step[1:0], cmd.step[3:2]}];
        mul_b = vm_r[{cmd.step[5:4], cmd.step[1:0]}];
        first = (cmd.step[1:0] == 2'd0);
        last  = (cmd.step[1:0] == 2'd3);
      end
      MM_CLIP: begin
        mul_a = vp_r[{cmd.step[1:0], cmd.step[3:2]}];
        mul_b = wp;
        first = (cmd.step[1:0] == 2'd0);
        last  = (cmd.step[1:0] == 2'd3);
      end
      MM_SCR: begin
        unique case (cmd.step[2:0])
          3'd0: begin mul_a = nd_r[0]; mul_b = HALF; end
          3'd1: begin mul_a = nd_r[1]; mul_b = HALF; end
          3'd2: begin mul_a = nd_r[2]; mul_b = HALF; end
          3'd3: begin mul_a = u_r[0]; mul_b = q_t'({vp_w, {FRAC_BITS{1'b0}}}); end
          3'd4: begin mul_a = u_r[1]; mul_b = q_t'({vp_h, {FRAC_BITS{1'b0}}}); end
          default: ;
        endcase
      end
      MM_SSQ: begin
        mul_a = pv_r[cmd.step[1:0]];
        mul_b = pv_r[cmd.step[1:0]];
        first = (cmd.step[1:0] == 2'd0);
        last  = (cmd.step[1:0] == 2'd2);
      end
      default: ;
    endcase
  end

  assign mag_a = mul_a[WORD_W-1] ? WORD_W'(-mul_a) : mul_a;
  assign mag_b = mul_b[WORD_W-1] ? WORD_W'(-mul_b) : mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else d_valid_r <= cmd.mac_go;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_go) begin
      prod_mag_r <= PROD_W'(mag_a) * PROD_W'(mag_b);
      prod_neg_r <= mul_a[WORD_W-1] ^ mul_b[WORD_W-1];
      d_first_r  <= first;
      d_last_r   <= last;
      d_mode_r   <= cmd.mac_mode;
      d_step_r   <= cmd.step;
    end
  end

  // rounding, sign and accumulate
  logic [PROD_W-1:0]       rnd_w;
  logic signed [ACC_W-1:0] rnd_m, prod_s, add_v, base_v, acc_nxt;
  q_t                      acc_sat;
  logic                    d_scr;

  assign rnd_w  = prod_mag_r + PROD_W'(HALF);
  assign rnd_m  = {{(ACC_W-SUMSQ_W){1'b0}}, rnd_w[PROD_W-1:FRAC_BITS]};
  assign prod_s = prod_neg_r ? -rnd_m : rnd_m;
  assign d_scr  = (d_mode_r == MM_SCR);
  assign add_v  = d_scr ? ext_q(sat_q(prod_s)) : prod_s;

  always_comb begin
    base_v = '0;
    if (d_scr && d_step_r[2:0] == 3'd3)
      base_v = ACC_W'({org_x, {FRAC_BITS{1'b0}}});
    else if (d_scr && d_step_r[2:0] == 3'd4)
      base_v = ACC_W'({org_y, {FRAC_BITS{1'b0}}});
  end

  assign acc_nxt = (d_first_r ? base_v : acc_r) + add_v;
  assign acc_sat = sat_q(acc_nxt);

  always_ff @(posedge clk) begin
    if (d_valid_r) acc_r <= acc_nxt;
    if (d_valid_r && d_last_r) begin
      unique case (d_mode_r)
        MM_VP:   vp_r[{d_step_r[5:4], d_step_r[3:2]}] <= acc_sat;
        MM_CLIP: clip_r[d_step_r[3:2]] <= acc_sat;
        MM_SCR: begin
          unique case (d_step_r[2:0])
            3'd0: u_r[0] <= acc_sat;
            3'd1: u_r[1] <= acc_sat;
            3'd2: scr_r[2] <= acc_sat;
            3'd3: scr_r[0] <= acc_sat;
            3'd4: scr_r[1] <= acc_sat;
            default: ;
          endcase
        end
        MM_SSQ:  s_r <= acc_nxt[SUMSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix loads and point capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        pm_r[i] <= (i % 5 == 0) ? ONE : '0;
        vm_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (in_accept && in_word.operation == OP_LOAD) begin
      if (in_word.matrix_select) pm_r[in_word.element_index] <= in_word.element_value;
      else vm_r[in_word.element_index] <= in_word.element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pt_r[0] <= in_word.world_x;
      pt_r[1] <= in_word.world_y;
      pt_r[2] <= in_word.world_z;
    end
  end

  // plane rows: row 3 plus or minus row k/2, one column per two steps
  logic [1:0] pl_col;
  logic [3:0] pl_addr;
  q_t         pl_rd;
  logic signed [ACC_W-1:0] pl_sum;

  assign pl_col  = cmd.pl_step[2:1];
  assign pl_addr = cmd.pl_step[0] ? {pl_col, cmd.plane_k[2:1]} : {pl_col, 2'd3};
  assign pl_rd   = vp_r[pl_addr];
  assign pl_sum  = cmd.plane_k[0] ? ext_q(tmp_r) - ext_q(pl_rd)
                                  : ext_q(tmp_r) + ext_q(pl_rd);

  always_ff @(posedge clk) begin
    if (cmd.pl_go) begin
      if (!cmd.pl_step[0]) tmp_r <= pl_rd;
      else pv_r[pl_col] <= sat_q(pl_sum);
    end
  end

  // divide and square root units
  q_t                div_num, div_q, clip_w;
  logic [WORD_W-1:0] div_den, sq_root;
  logic              div_den_neg, div_busy, div_done, sq_busy, sq_done;

  assign clip_w      = clip_r[3];
  assign div_num     = cmd.div_plane ? pv_r[cmd.div_sel] : clip_r[cmd.div_sel];
  assign div_den     = cmd.div_plane ? sq_root
                                     : (clip_w[WORD_W-1] ? WORD_W'(-clip_w) : clip_w);
  assign div_den_neg = cmd.div_plane ? 1'b0 : clip_w[WORD_W-1];

  cpf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num     (div_num),
    .den_mag (div_den),
    .den_neg (div_den_neg),
    .busy    (div_busy),
    .done    (div_done),
    .quo     (div_q)
  );

  cpf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .rad   ({s_r, {FRAC_BITS{1'b0}}}),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (cmd.div_plane) pa_r[cmd.div_sel] <= div_q;
      else nd_r[cmd.div_sel] <= sat_q(ext_q(div_q) + ext_q(ONE));
    end
  end

  // output word register
  always_comb begin
    out_nxt = '0;
    if (cmd.emit_plane) begin
      out_nxt.plane_index = cmd.plane_k;
      out_nxt.last_of_run = (cmd.plane_k == PLANE_FAR);
      if (sq_root == '0) begin
        out_nxt.status = ST_LEN_ZERO;
      end else begin
        out_nxt.status  = ST_OK;
        out_nxt.plane_a = pa_r[0];
        out_nxt.plane_b = pa_r[1];
        out_nxt.plane_c = pa_r[2];
        out_nxt.plane_d = pa_r[3];
      end
    end else begin
      out_nxt.last_of_run = 1'b1;
      if (clip_w == '0) begin
        out_nxt.status = ST_W_ZERO;
      end else begin
        out_nxt.status       = ST_OK;
        out_nxt.screen_x     = scr_r[0];
        out_nxt.screen_y     = scr_r[1];
        out_nxt.screen_depth = scr_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;
  assign sts.sq_done  = sq_done;
  assign sts.sq_busy  = sq_busy;
  assign sts.w_zero   = (clip_w == '0);
  assign sts.len_zero = (sq_root == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

[rtl/core/camera_projection_and_frustum_unit.sv]
// ----------------------------------------------------------------------------
// camera_projection_and_frustum_unit
// World-to-screen projection and frustum plane extraction from a view and a
// projection matrix held in Q16.16.
// ----------------------------------------------------------------------------
// Usage: words enter on in_valid/in_stall, results leave on out_valid/
// out_stall; a word moves when valid is high and stall is low.
// A load word writes one matrix element and gives no result. A project word
// gives one result; a frustum word gives six plane words. Both forms start
// by rebuilding projection times view on the single shared multiplier; the
// rest runs on the bit-serial divider and the bit-serial square root.
// One word is worked on at a time; in_stall is high while it is in flight.
// The output register lets the next word be taken while a result waits;
// while that result waits and out_stall is high, the unit holds before
// writing its next result.
// Reset loads both matrices with the identity and the viewport with
// origin 0,0 and size 1024 x 768. Viewport registers sit on the APB port at
// byte addresses 0, 4, 8 and 12. The user must write them only while the
// unit is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module camera_projection_and_frustum_unit
  import cpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [13:0] org_x_r, org_y_r;
  logic [14:0] vp_w_r, vp_h_r;
  logic        cfg_wr, in_accept;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      vp_w_r  <= 15'd1024;
      vp_h_r  <= 15'd768;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORIGIN_X: org_x_r <= pwdata[13:0];
        REG_ORIGIN_Y: org_y_r <= pwdata[13:0];
        REG_WIDTH:    vp_w_r  <= pwdata[14:0];
        REG_HEIGHT:   vp_h_r  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORIGIN_X: prdata = 32'(org_x_r);
      REG_ORIGIN_Y: prdata = 32'(org_y_r);
      REG_WIDTH:    prdata = 32'(vp_w_r);
      REG_HEIGHT:   prdata = 32'(vp_h_r);
      default:      prdata = '0;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  cpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (op_t'(in_word.operation)),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  cpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_word   (in_word),
    .org_x     (org_x_r),
    .org_y     (org_y_r),
    .vp_w      (vp_w_r),
    .vp_h      (vp_h_r),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({sts.div_busy, sts.sq_busy}))
    else $error("divider and square root busy together");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divide started while divider busy");

  a_sq_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_start |=> sts.sq_busy)
    else $error("square root did not start");

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result written over a stalled word");

endmodule

[test/camera_projection_and_frustum_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_projection_and_frustum_unit_test
// Self-checking bench for the projection and frustum unit. Directed words
// cover field extremes, zero clip w, zero plane length and the unused
// operation. Random load/project/frustum/unused words follow under several
// viewport settings. An in-bench fixed-point model predicts every result
// word. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module camera_projection_and_frustum_unit_test;
  import cpf_pkg::*;

  localparam int    LIMIT_CYCLES = 3000000;
  localparam longint QONE        = 64'sd1 << 16;
  localparam longint QHALF       = 64'sd1 << 15;
  localparam logic [63:0] CAP    = 64'd1 << 60;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_word_t    in_word;
  out_word_t   out_word;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  camera_projection_and_frustum_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  longint    view_m[16], proj_m[16];
  longint    org_x, org_y, vp_w, vp_h;
  int        cycle_count, fail_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [63:0]  ua, ub;
    logic [127:0] pr;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    pr = {64'd0, ua} * {64'd0, ub};
    pr = (pr + (128'd1 << 15)) >> 16;
    if (pr > {64'd0, CAP}) pr = {64'd0, CAP};
    return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [63:0] un, ud, q, rem;
    logic        neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    rem = un % ud;
    if (q > (CAP >> 16)) q = CAP;
    else begin
      for (int i = 0; i <= 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          q[0] = 1'b1;
        end
      end
      q = (q + 1) >> 1;
    end
    return clamp_word(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic [63:0] int_sqrt(logic [127:0] v);
    logic [127:0] root, rem, trial;
    root = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      trial = (root << 2) | 128'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint sext_field(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic quiet_stretch();
    return cycle_count >= 30000 && cycle_count < 60000;
  endfunction

  // predicts the result words of one accepted input word
  task automatic predict_results(input in_word_t w);
    longint    vpm[16], pt[4], clip[4], pl[4];
    longint    acc, nx, ny, nz, sx, sy, sz;
    logic [63:0] ssum, len;
    out_word_t r;
    int        row;
    case (op_t'(w.operation))
      OP_LOAD: begin
        if (w.matrix_select) proj_m[w.element_index] = sext_field(w.element_value);
        else view_m[w.element_index] = sext_field(w.element_value);
      end
      OP_PROJECT, OP_FRUSTUM: begin
        for (int c = 0; c < 4; c++)
          for (int rr = 0; rr < 4; rr++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += qmul(proj_m[k*4+rr], view_m[c*4+k]);
            vpm[c*4+rr] = clamp_word(acc);
          end
        if (op_t'(w.operation) == OP_PROJECT) begin
          r = '0;
          r.last_of_run = 1'b1;
          pt[0] = sext_field(w.world_x);
          pt[1] = sext_field(w.world_y);
          pt[2] = sext_field(w.world_z);
          pt[3] = QONE;
          for (int rr = 0; rr < 4; rr++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) acc += qmul(vpm[c*4+rr], pt[c]);
            clip[rr] = clamp_word(acc);
          end
          if (clip[3] == 0) r.status = ST_W_ZERO;
          else begin
            nx = qdiv(clip[0], clip[3]);
            ny = qdiv(clip[1], clip[3]);
            nz = qdiv(clip[2], clip[3]);
            sx = clamp_word((org_x << 16) + clamp_word(qmul(clamp_word(qmul(
                   clamp_word(nx + QONE), QHALF)), clamp_word(vp_w << 16))));
            sy = clamp_word((org_y << 16) + clamp_word(qmul(clamp_word(qmul(
                   clamp_word(ny + QONE), QHALF)), clamp_word(vp_h << 16))));
            sz = clamp_word(qmul(clamp_word(nz + QONE), QHALF));
            r.screen_x = sx[31:0];
            r.screen_y = sy[31:0];
            r.screen_depth = sz[31:0];
            r.status = ST_OK;
          end
          expected_words.push_back(r);
        end else begin
          for (int k = 0; k < 6; k++) begin
            r = '0;
            row = k / 2;
            for (int c = 0; c < 4; c++)
              pl[c] = clamp_word((k & 1) ? vpm[c*4+3] - vpm[c*4+row]
                                         : vpm[c*4+3] + vpm[c*4+row]);
            ssum = qmul(pl[0], pl[0]) + qmul(pl[1], pl[1]) + qmul(pl[2], pl[2]);
            len = int_sqrt({64'd0, ssum} << 16);
            r.plane_index = 3'(k);
            r.last_of_run = (3'(k) == PLANE_FAR);
            if (len == 0) r.status = ST_LEN_ZERO;
            else begin
              r.plane_a = 32'(qdiv(pl[0], longint'(len)));
              r.plane_b = 32'(qdiv(pl[1], longint'(len)));
              r.plane_c = 32'(qdiv(pl[2], longint'(len)));
              r.plane_d = 32'(qdiv(pl[3], longint'(len)));
              r.status = ST_OK;
            end
            expected_words.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  task automatic queue_word(input op_t op, input logic sel, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    in_word_t w;
    w.operation = op;
    w.matrix_select = sel;
    w.element_index = idx;
    w.element_value = val;
    w.world_x = x;
    w.world_y = y;
    w.world_z = z;
    pending_words.push_back(w);
  endtask

  task automatic queue_random(input op_t op);
    queue_word(op, $urandom_range(0, 1), $urandom_range(0, 15), rand_q(),
               rand_q(), rand_q(), rand_q());
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ORIGIN_X: org_x = val & 32'h3FFF;
      REG_ORIGIN_Y: org_y = val & 32'h3FFF;
      REG_WIDTH:    vp_w = val & 32'h7FFF;
      default:      vp_h = val & 32'h7FFF;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int pick;
    // set the diagonals of both matrices to one before the random words
    for (int i = 0; i < 4; i++) begin
      queue_word(OP_LOAD, 1'b0, 4'(i * 5), 32'h0001_0000, $urandom, $urandom, $urandom);
      queue_word(OP_LOAD, 1'b1, 4'(i * 5), 32'h0001_0000, $urandom, $urandom, $urandom);
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) queue_random(OP_LOAD);
      else if (pick < 85) queue_random(OP_PROJECT);
      else if (pick < 96) queue_random(OP_FRUSTUM);
      else queue_random(OP_NONE);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = (i % 5 == 0) ? QONE : 0;
      proj_m[i] = view_m[i];
    end
    org_x = 0;
    org_y = 0;
    vp_w = 1024;
    vp_h = 768;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, extremes, zero w, zero plane length, unused op
    queue_word(OP_PROJECT, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_word(OP_PROJECT, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0000_8000);
    queue_word(OP_FRUSTUM, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_word(OP_LOAD, 1'b0, 4'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    queue_word(OP_LOAD, 1'b0, 4'd5, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
    queue_word(OP_PROJECT, 1'b0, 4'd0, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    queue_word(OP_FRUSTUM, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_word(OP_NONE, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    queue_word(OP_LOAD, 1'b1, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_word(OP_PROJECT, 1'b0, 4'd0, 32'd0, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    queue_word(OP_LOAD, 1'b1, 4'd15, 32'h0000_0001, 32'd0, 32'd0, 32'd0);
    queue_word(OP_PROJECT, 1'b0, 4'd0, 32'd0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    // zero view matrix: clip w and every plane length vanish
    for (int i = 0; i < 4; i++)
      queue_word(OP_LOAD, 1'b0, 4'(i * 5), 32'd0, 32'd0, 32'd0, 32'd0);
    queue_word(OP_PROJECT, 1'b0, 4'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
    queue_word(OP_FRUSTUM, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(80);
    drain();

    reg_write(REG_ORIGIN_X, 32'd16383);
    reg_write(REG_ORIGIN_Y, 32'd0);
    reg_write(REG_WIDTH, 32'd16384);
    reg_write(REG_HEIGHT, 32'd1);
    random_phase(90);
    drain();

    reg_write(REG_ORIGIN_X, 32'd0);
    reg_write(REG_ORIGIN_Y, 32'd16383);
    reg_write(REG_WIDTH, 32'd0);
    reg_write(REG_HEIGHT, 32'd32767);
    random_phase(90);
    drain();

    reg_write(REG_ORIGIN_X, $urandom_range(0, 16383));
    reg_write(REG_ORIGIN_Y, $urandom_range(0, 16383));
    reg_write(REG_WIDTH, $urandom_range(1, 16384));
    reg_write(REG_HEIGHT, $urandom_range(1, 16384));
    random_phase(90);
    drain();

    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // word source: fills a free slot from the pending queue, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_results(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 &&
            (quiet_stretch() || $urandom_range(0, 99) >= 24)) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker with random back-pressure
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", out_word);
        end else begin
          want = expected_words.pop_front();
          if (out_word !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch\n  expected %p\n  actual   %p", want, out_word);
          end
        end
      end
      out_stall <= !quiet_stretch() && $urandom_range(0, 99) < 24;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
